@@ rtl/ccc_pkg.sv @@
// Shared types and codes for the circle contact pipeline.
// No dependencies.
package ccc_pkg;

  localparam logic [1:0] OP_AABB   = 2'd0;
  localparam logic [1:0] OP_OBB    = 2'd1;
  localparam logic [1:0] OP_CIRCLE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] FACE_TOP    = 2'd0;
  localparam logic [1:0] FACE_BOTTOM = 2'd1;
  localparam logic [1:0] FACE_LEFT   = 2'd2;
  localparam logic [1:0] FACE_RIGHT  = 2'd3;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  localparam int SQRT_W   = 64;
  localparam int SQRT_LN  = 2;
  localparam int DIV_DW   = 32;
  localparam int DIV_QW   = 31;
  localparam int DIV_LN   = 4;

  typedef struct packed {
    logic               hit;
    logic [1:0]         op;
    logic               in_box;
    logic [1:0]         face;
    logic               neg_x;
    logic               neg_y;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [62:0]        off_x_num;
    logic [62:0]        off_y_num;
    logic signed [35:0] base_x;
    logic signed [35:0] base_y;
    logic [31:0]        sub;
  } tag_t;

  typedef struct packed {
    tag_t        t;
    logic [31:0] mag;
    logic [16:0] fric;
  } post_t;

endpackage

@@ rtl/ccc_sqrt.sv @@
// Pipelined floor square root, one result bit per stage, several lanes.
// Uses nothing outside this file.
module ccc_sqrt #(
  parameter int W     = 64,
  parameter int LANES = 2,
  parameter int TW    = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [W-1:0]       in_rad [LANES],
  input  logic [TW-1:0]      in_tag,
  output logic               out_valid,
  output logic [W/2-1:0]     out_root [LANES],
  output logic [TW-1:0]      out_tag
);

  localparam int N = W / 2;

  logic [W-1:0]  rem  [N][LANES];
  logic [W-1:0]  root [N][LANES];
  logic [TW-1:0] tagr [N];
  logic          vld  [N];

  for (genvar i = 0; i < N; i++) begin : g_st
    localparam logic [W-1:0] B = W'(1) << (W - 2 - 2 * i);
    logic [W-1:0]  rin [LANES];
    logic [W-1:0]  qin [LANES];
    logic [TW-1:0] tin;
    logic          vin;

    if (i == 0) begin : g_first
      assign tin = in_tag;
      assign vin = in_valid;
      for (genvar j = 0; j < LANES; j++) begin : g_ln
        assign rin[j] = in_rad[j];
        assign qin[j] = '0;
      end
    end else begin : g_next
      assign tin = tagr[i-1];
      assign vin = vld[i-1];
      for (genvar j = 0; j < LANES; j++) begin : g_ln
        assign rin[j] = rem[i-1][j];
        assign qin[j] = root[i-1][j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tagr[i] <= tin;
      end
    end

    for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [W:0] trial;
      logic       ge;
      assign trial = {1'b0, qin[j]} + {1'b0, B};
      assign ge    = {1'b0, rin[j]} >= trial;
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i][j]  <= ge ? rin[j] - trial[W-1:0] : rin[j];
          root[i][j] <= ge ? (qin[j] >> 1) + B : (qin[j] >> 1);
        end
      end
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_out
    assign out_root[j] = root[N-1][j][N-1:0];
  end
  assign out_tag   = tagr[N-1];
  assign out_valid = vld[N-1];

endmodule

@@ rtl/ccc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, lanes share the divisor.
// Uses nothing outside this file.
module ccc_div #(
  parameter int DW    = 32,
  parameter int QW    = 31,
  parameter int LANES = 4,
  parameter int TW    = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [DW+QW-1:0]    num [LANES],
  input  logic [DW-1:0]       den,
  input  logic [TW-1:0]       in_tag,
  output logic                out_valid,
  output logic [QW-1:0]       quo [LANES],
  output logic [TW-1:0]       out_tag
);

  localparam int CW = DW + QW;

  logic [CW-1:0] rem  [QW][LANES];
  logic [QW-1:0] qr   [QW][LANES];
  logic [DW-1:0] dreg [QW];
  logic [TW-1:0] tagr [QW];
  logic          vld  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_st
    localparam int K = QW - 1 - i;
    logic [DW-1:0] din;
    logic [TW-1:0] tin;
    logic          vin;
    logic [CW-1:0] rin [LANES];
    logic [QW-1:0] qin [LANES];

    if (i == 0) begin : g_first
      assign din = den;
      assign tin = in_tag;
      assign vin = in_valid;
      for (genvar j = 0; j < LANES; j++) begin : g_ln
        assign rin[j] = num[j];
        assign qin[j] = '0;
      end
    end else begin : g_next
      assign din = dreg[i-1];
      assign tin = tagr[i-1];
      assign vin = vld[i-1];
      for (genvar j = 0; j < LANES; j++) begin : g_ln
        assign rin[j] = rem[i-1][j];
        assign qin[j] = qr[i-1][j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dreg[i] <= din;
        tagr[i] <= tin;
      end
    end

    for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [CW-1:0] sh;
      logic          ge;
      assign sh = CW'(din) << K;
      assign ge = rin[j] >= sh;
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i][j] <= ge ? rin[j] - sh : rin[j];
          qr[i][j]  <= qin[j] | (ge ? (QW'(1) << K) : '0);
        end
      end
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_out
    assign quo[j] = qr[QW-1][j];
  end
  assign out_tag   = tagr[QW-1];
  assign out_valid = vld[QW-1];

endmodule

@@ rtl/ccc_front.sv @@
// Geometry front end: clamp, rotate, distance squares and overlap test (9 stages).
// Depends on ccc_pkg.
module ccc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [1:0]          op,
  input  logic signed [31:0]  self_x,
  input  logic signed [31:0]  self_y,
  input  logic [30:0]         self_radius,
  input  logic signed [31:0]  other_x,
  input  logic signed [31:0]  other_y,
  input  logic [30:0]         other_ext_x,
  input  logic [30:0]         other_ext_y,
  input  logic signed [15:0]  other_cos,
  input  logic signed [15:0]  other_sin,
  input  logic [16:0]         self_friction,
  input  logic [16:0]         other_friction,
  output logic                out_valid,
  output logic [63:0]         out_sum,
  output logic [33:0]         out_fric,
  output ccc_pkg::tag_t       out_tag
);

  logic [8:0] vld;

  // stage 1
  logic [1:0]         op1;
  logic signed [31:0] px1, py1, ox1, oy1;
  logic [30:0]        r1, hx1, hy1;
  logic signed [15:0] cs1, sn1;
  logic signed [32:0] dxo1, dyo1;
  logic signed [33:0] lox1, hix1, loy1, hiy1;
  logic [31:0]        sumr1;
  logic [33:0]        fp1;
  // stage 2
  logic [1:0]         op2;
  logic signed [31:0] px2, py2, ox2, oy2;
  logic [30:0]        r2, hx2, hy2;
  logic signed [15:0] cs2, sn2;
  logic [31:0]        sumr2;
  logic [33:0]        fp2;
  logic signed [48:0] pxc2, pys2, pxs2, pyc2;
  logic signed [33:0] nxp2, nyp2;
  logic signed [34:0] dist2 [4];
  logic [61:0]        rr2;
  logic [63:0]        ss2;
  // stage 3
  logic [1:0]         op3;
  logic signed [31:0] px3, py3, ox3, oy3;
  logic [30:0]        r3;
  logic signed [15:0] cs3, sn3;
  logic [31:0]        sumr3;
  logic [33:0]        fp3;
  logic signed [31:0] rx3, ry3;
  logic signed [34:0] dx3, dy3;
  logic signed [33:0] nxp3, nyp3;
  logic [1:0]         face3;
  logic [63:0]        bound3;
  // stage 4
  logic [1:0]         op4;
  logic signed [31:0] px4, py4, ox4, oy4;
  logic [30:0]        r4;
  logic [31:0]        sumr4;
  logic [33:0]        fp4;
  logic signed [47:0] prxc4, prys4, prxs4, pryc4;
  logic signed [34:0] dx4, dy4;
  logic signed [33:0] nxp4, nyp4;
  logic [1:0]         face4;
  logic [63:0]        bound4;
  // stage 5
  logic [1:0]         op5;
  logic signed [31:0] px5, py5, ox5, oy5;
  logic [30:0]        r5;
  logic [31:0]        sumr5;
  logic [33:0]        fp5;
  logic signed [35:0] gx5, gy5;
  logic signed [34:0] dx5, dy5;
  logic signed [33:0] nxp5, nyp5;
  logic [1:0]         face5;
  logic [63:0]        bound5;
  // stage 6
  logic               ok6, strict6, inbox6;
  logic [1:0]         op6, face6;
  logic signed [36:0] ex6, ey6;
  logic signed [35:0] bx6, by6;
  logic [31:0]        sub6;
  logic [30:0]        r6;
  logic [63:0]        bound6;
  logic [33:0]        fp6;
  // stage 7
  logic               ok7, strict7, inbox7, negx7, negy7, far7;
  logic [1:0]         op7, face7;
  logic [31:0]        ax7, ay7;
  logic signed [35:0] bx7, by7;
  logic [31:0]        sub7;
  logic [30:0]        r7;
  logic [63:0]        bound7;
  logic [33:0]        fp7;
  // stage 8
  logic               ok8, strict8, inbox8, negx8, negy8, far8;
  logic [1:0]         op8, face8;
  logic [31:0]        ax8, ay8;
  logic signed [35:0] bx8, by8;
  logic [31:0]        sub8;
  logic [63:0]        bound8;
  logic [33:0]        fp8;
  logic [63:0]        sx8, sy8;
  logic [62:0]        offx8, offy8;
  // stage 9
  logic [63:0]        s9;
  logic [33:0]        fp9;
  ccc_pkg::tag_t      tag9;

  // combinational helpers
  logic signed [33:0] px34, py34, tx_c, ty_c, nxp_c, nyp_c;
  logic signed [49:0] vx_c, vy_c;
  logic signed [35:0] sx_c, sy_c, hx36, hy36, rx_c, ry_c;
  logic               b01, b23;
  logic signed [34:0] m01, m23;
  logic [1:0]         i01, i23;
  logic signed [48:0] gxs_c, gys_c;
  logic signed [36:0] ex_c, ey_c;
  logic signed [35:0] bx_c, by_c;
  logic [36:0]        mx_c, my_c;
  logic [64:0]        s_c;
  logic               hit_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:0], in_valid};
    end
  end

  always_comb begin
    px34  = 34'(px1);
    py34  = 34'(py1);
    tx_c  = (px34 < hix1) ? px34 : hix1;
    nxp_c = (tx_c < lox1) ? lox1 : tx_c;
    ty_c  = (py34 < hiy1) ? py34 : hiy1;
    nyp_c = (ty_c < loy1) ? loy1 : ty_c;
  end

  always_comb begin
    vx_c = 50'(pxc2) + 50'(pys2) + 50'sd8192;
    vy_c = 50'(pyc2) - 50'(pxs2) + 50'sd8192;
    sx_c = 36'(vx_c >>> 14);
    sy_c = 36'(vy_c >>> 14);
    hx36 = $signed({5'b00000, hx2});
    hy36 = $signed({5'b00000, hy2});
    rx_c = (sx_c > hx36) ? hx36 : ((sx_c < -hx36) ? -hx36 : sx_c);
    ry_c = (sy_c > hy36) ? hy36 : ((sy_c < -hy36) ? -hy36 : sy_c);
    // first minimum wins on ties
    b01 = dist2[1] < dist2[0];
    m01 = b01 ? dist2[1] : dist2[0];
    i01 = b01 ? ccc_pkg::FACE_BOTTOM : ccc_pkg::FACE_TOP;
    b23 = dist2[3] < dist2[2];
    m23 = b23 ? dist2[3] : dist2[2];
    i23 = b23 ? ccc_pkg::FACE_RIGHT : ccc_pkg::FACE_LEFT;
  end

  always_comb begin
    gxs_c = (49'(prxc4) - 49'(prys4) + 49'sd8192) >>> 14;
    gys_c = (49'(prxs4) + 49'(pryc4) + 49'sd8192) >>> 14;
  end

  always_comb begin
    case (op5)
      ccc_pkg::OP_AABB: begin
        ex_c = 37'(dx5);
        ey_c = 37'(dy5);
        bx_c = 36'(nxp5);
        by_c = 36'(nyp5);
      end
      ccc_pkg::OP_OBB: begin
        ex_c = 37'(px5) - 37'(gx5);
        ey_c = 37'(py5) - 37'(gy5);
        bx_c = gx5;
        by_c = gy5;
      end
      ccc_pkg::OP_CIRCLE: begin
        ex_c = 37'(ox5) - 37'(px5);
        ey_c = 37'(oy5) - 37'(py5);
        bx_c = 36'(px5);
        by_c = 36'(py5);
      end
      default: begin
        ex_c = '0;
        ey_c = '0;
        bx_c = '0;
        by_c = '0;
      end
    endcase
  end

  always_comb begin
    mx_c  = ex6[36] ? 37'(-ex6) : 37'(ex6);
    my_c  = ey6[36] ? 37'(-ey6) : 37'(ey6);
    s_c   = {1'b0, sx8} + {1'b0, sy8};
    hit_c = ok8 && !far8 &&
            (strict8 ? (s_c < {1'b0, bound8}) : (s_c <= {1'b0, bound8}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // 1: offsets, box bounds, friction product
      op1   <= op;
      px1   <= self_x;
      py1   <= self_y;
      ox1   <= other_x;
      oy1   <= other_y;
      r1    <= self_radius;
      hx1   <= other_ext_x;
      hy1   <= other_ext_y;
      cs1   <= other_cos;
      sn1   <= other_sin;
      dxo1  <= 33'(self_x) - 33'(other_x);
      dyo1  <= 33'(self_y) - 33'(other_y);
      lox1  <= 34'(other_x) - $signed({3'b000, other_ext_x});
      hix1  <= 34'(other_x) + $signed({3'b000, other_ext_x});
      loy1  <= 34'(other_y) - $signed({3'b000, other_ext_y});
      hiy1  <= 34'(other_y) + $signed({3'b000, other_ext_y});
      sumr1 <= {1'b0, other_ext_x} + {1'b0, self_radius};
      fp1   <= 34'(self_friction) * 34'(other_friction);
      // 2: rotate into box frame, clamp, face distances, radius squares
      op2   <= op1;
      px2   <= px1;
      py2   <= py1;
      ox2   <= ox1;
      oy2   <= oy1;
      r2    <= r1;
      hx2   <= hx1;
      hy2   <= hy1;
      cs2   <= cs1;
      sn2   <= sn1;
      sumr2 <= sumr1;
      fp2   <= fp1;
      pxc2  <= 49'(dxo1) * 49'(cs1);
      pys2  <= 49'(dyo1) * 49'(sn1);
      pxs2  <= 49'(dxo1) * 49'(sn1);
      pyc2  <= 49'(dyo1) * 49'(cs1);
      nxp2  <= nxp_c;
      nyp2  <= nyp_c;
      dist2[0] <= 35'(hiy1) - 35'(py1);
      dist2[1] <= 35'(py1) - 35'(loy1);
      dist2[2] <= 35'(px1) - 35'(lox1);
      dist2[3] <= 35'(hix1) - 35'(px1);
      rr2   <= 62'(r1) * 62'(r1);
      ss2   <= 64'(sumr1) * 64'(sumr1);
      // 3
      op3   <= op2;
      px3   <= px2;
      py3   <= py2;
      ox3   <= ox2;
      oy3   <= oy2;
      r3    <= r2;
      cs3   <= cs2;
      sn3   <= sn2;
      sumr3 <= sumr2;
      fp3   <= fp2;
      rx3   <= 32'(rx_c);
      ry3   <= 32'(ry_c);
      dx3   <= 35'(px2) - 35'(nxp2);
      dy3   <= 35'(py2) - 35'(nyp2);
      nxp3  <= nxp2;
      nyp3  <= nyp2;
      face3 <= (m23 < m01) ? i23 : i01;
      bound3 <= (op2 == ccc_pkg::OP_CIRCLE) ? ss2 : 64'(rr2);
      // 4: rotate clamped point back
      op4   <= op3;
      px4   <= px3;
      py4   <= py3;
      ox4   <= ox3;
      oy4   <= oy3;
      r4    <= r3;
      sumr4 <= sumr3;
      fp4   <= fp3;
      prxc4 <= 48'(rx3) * 48'(cs3);
      prys4 <= 48'(ry3) * 48'(sn3);
      prxs4 <= 48'(rx3) * 48'(sn3);
      pryc4 <= 48'(ry3) * 48'(cs3);
      dx4   <= dx3;
      dy4   <= dy3;
      nxp4  <= nxp3;
      nyp4  <= nyp3;
      face4 <= face3;
      bound4 <= bound3;
      // 5
      op5   <= op4;
      px5   <= px4;
      py5   <= py4;
      ox5   <= ox4;
      oy5   <= oy4;
      r5    <= r4;
      sumr5 <= sumr4;
      fp5   <= fp4;
      gx5   <= 36'(gxs_c) + 36'(ox4);
      gy5   <= 36'(gys_c) + 36'(oy4);
      dx5   <= dx4;
      dy5   <= dy4;
      nxp5  <= nxp4;
      nyp5  <= nyp4;
      face5 <= face4;
      bound5 <= bound4;
      // 6: per-shape separation vector and contact base
      ok6     <= op5 inside {ccc_pkg::OP_AABB, ccc_pkg::OP_OBB, ccc_pkg::OP_CIRCLE};
      strict6 <= op5 == ccc_pkg::OP_AABB;
      inbox6  <= (op5 == ccc_pkg::OP_AABB) && (dx5 == '0) && (dy5 == '0);
      op6     <= op5;
      face6   <= face5;
      ex6     <= ex_c;
      ey6     <= ey_c;
      bx6     <= bx_c;
      by6     <= by_c;
      sub6    <= (op5 == ccc_pkg::OP_CIRCLE) ? sumr5 : {1'b0, r5};
      r6      <= r5;
      bound6  <= bound5;
      fp6     <= fp5;
      // 7: magnitudes
      ok7     <= ok6;
      strict7 <= strict6;
      inbox7  <= inbox6;
      op7     <= op6;
      face7   <= face6;
      negx7   <= ex6[36];
      negy7   <= ey6[36];
      ax7     <= mx_c[31:0];
      ay7     <= my_c[31:0];
      far7    <= (mx_c[36:32] != '0) || (my_c[36:32] != '0);
      bx7     <= bx6;
      by7     <= by6;
      sub7    <= sub6;
      r7      <= r6;
      bound7  <= bound6;
      fp7     <= fp6;
      // 8: squares and offset numerators
      ok8     <= ok7;
      strict8 <= strict7;
      inbox8  <= inbox7;
      op8     <= op7;
      face8   <= face7;
      negx8   <= negx7;
      negy8   <= negy7;
      ax8     <= ax7;
      ay8     <= ay7;
      far8    <= far7;
      bx8     <= bx7;
      by8     <= by7;
      sub8    <= sub7;
      bound8  <= bound7;
      fp8     <= fp7;
      sx8     <= 64'(ax7) * 64'(ax7);
      sy8     <= 64'(ay7) * 64'(ay7);
      offx8   <= 63'(ax7) * 63'(r7);
      offy8   <= 63'(ay7) * 63'(r7);
      // 9: overlap test
      s9               <= s_c[63:0];
      fp9              <= fp8;
      tag9.hit         <= hit_c;
      tag9.op          <= op8;
      tag9.in_box      <= inbox8;
      tag9.face        <= face8;
      tag9.neg_x       <= negx8;
      tag9.neg_y       <= negy8;
      tag9.ax          <= ax8;
      tag9.ay          <= ay8;
      tag9.off_x_num   <= offx8;
      tag9.off_y_num   <= offy8;
      tag9.base_x      <= bx8;
      tag9.base_y      <= by8;
      tag9.sub         <= sub8;
    end
  end

  assign out_valid = vld[8];
  assign out_sum   = s9;
  assign out_fric  = fp9;
  assign out_tag   = tag9;

endmodule

@@ rtl/circle_collision_contact_2d.sv @@
// Circle versus box, rotated box or circle contact test, one word per cycle.
// From input accept to output valid a word passes 9 geometry stages,
// 32 square-root stages, 31 divider stages and the output register.
// Throughput one word per clock; on an output stall a skid word takes one more word,
// then the whole pipeline and the input hold until the output moves.
// Synchronous active-high reset empties the pipeline; no other state.
module circle_collision_contact_2d (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [31:0] self_x,
  input  logic signed [31:0] self_y,
  input  logic [30:0]        self_radius,
  input  logic signed [31:0] other_x,
  input  logic signed [31:0] other_y,
  input  logic [30:0]        other_ext_x,
  input  logic [30:0]        other_ext_y,
  input  logic signed [15:0] other_cos,
  input  logic signed [15:0] other_sin,
  input  logic [16:0]        self_friction,
  input  logic [16:0]        other_friction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [31:0] contact_x,
  output logic signed [31:0] contact_y,
  output logic signed [31:0] separation,
  output logic [16:0]        combined_friction
);

  typedef struct packed {
    logic               hit;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] sep;
    logic [16:0]        fric;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return 32'(v);
    end
  endfunction

  logic          en;
  logic          fr_valid, sq_valid, dv_valid;
  logic [63:0]   fr_sum;
  logic [33:0]   fr_fric;
  ccc_pkg::tag_t fr_tag, sq_tag;
  logic [ccc_pkg::SQRT_W-1:0]   sq_in   [ccc_pkg::SQRT_LN];
  logic [ccc_pkg::SQRT_W/2-1:0] sq_root [ccc_pkg::SQRT_LN];
  logic [ccc_pkg::DIV_DW+ccc_pkg::DIV_QW-1:0] dv_num [ccc_pkg::DIV_LN];
  logic [ccc_pkg::DIV_QW-1:0]   dv_q    [ccc_pkg::DIV_LN];
  ccc_pkg::post_t dv_in_tag, dv_tag;

  res_t res_c, res_out, res_skid;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_ready = en;

  ccc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (in_valid),
    .op             (op),
    .self_x         (self_x),
    .self_y         (self_y),
    .self_radius    (self_radius),
    .other_x        (other_x),
    .other_y        (other_y),
    .other_ext_x    (other_ext_x),
    .other_ext_y    (other_ext_y),
    .other_cos      (other_cos),
    .other_sin      (other_sin),
    .self_friction  (self_friction),
    .other_friction (other_friction),
    .out_valid      (fr_valid),
    .out_sum        (fr_sum),
    .out_fric       (fr_fric),
    .out_tag        (fr_tag)
  );

  assign sq_in[0] = fr_sum;
  assign sq_in[1] = 64'(fr_fric);

  ccc_sqrt #(
    .W     (ccc_pkg::SQRT_W),
    .LANES (ccc_pkg::SQRT_LN),
    .TW    ($bits(ccc_pkg::tag_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_rad    (sq_in),
    .in_tag    (fr_tag),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  assign dv_num[0] = {17'd0, sq_tag.ax, 14'd0};
  assign dv_num[1] = {17'd0, sq_tag.ay, 14'd0};
  assign dv_num[2] = sq_tag.off_x_num;
  assign dv_num[3] = sq_tag.off_y_num;
  assign dv_in_tag.t    = sq_tag;
  assign dv_in_tag.mag  = sq_root[0];
  assign dv_in_tag.fric = sq_root[1][16:0];

  ccc_div #(
    .DW    (ccc_pkg::DIV_DW),
    .QW    (ccc_pkg::DIV_QW),
    .LANES (ccc_pkg::DIV_LN),
    .TW    ($bits(ccc_pkg::post_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .num       (dv_num),
    .den       (sq_root[0]),
    .in_tag    (dv_in_tag),
    .out_valid (dv_valid),
    .quo       (dv_q),
    .out_tag   (dv_tag)
  );

  // result assembly
  logic               mnz, negn_x, negn_y, circ;
  logic signed [15:0] qx, qy;
  logic signed [36:0] cx_c, cy_c, sep_c;

  always_comb begin
    circ   = dv_tag.t.op == ccc_pkg::OP_CIRCLE;
    mnz    = dv_tag.mag != '0;
    qx     = $signed(dv_q[0][15:0]);
    qy     = $signed(dv_q[1][15:0]);
    negn_x = circ ? dv_tag.t.neg_x : !dv_tag.t.neg_x;
    negn_y = circ ? dv_tag.t.neg_y : !dv_tag.t.neg_y;
    cx_c   = 37'(dv_tag.t.base_x);
    cy_c   = 37'(dv_tag.t.base_y);
    if (circ && mnz) begin
      cx_c = dv_tag.t.neg_x ? cx_c - $signed({6'd0, dv_q[2]})
                            : cx_c + $signed({6'd0, dv_q[2]});
      cy_c = dv_tag.t.neg_y ? cy_c - $signed({6'd0, dv_q[3]})
                            : cy_c + $signed({6'd0, dv_q[3]});
    end
    sep_c = $signed({5'd0, dv_tag.mag}) - $signed({5'd0, dv_tag.t.sub});

    res_c      = '0;
    res_c.hit  = 1'b1;
    res_c.cx   = sat32(cx_c);
    res_c.cy   = sat32(cy_c);
    res_c.sep  = sat32(sep_c);
    res_c.fric = dv_tag.fric;
    if (dv_tag.t.in_box) begin
      case (dv_tag.t.face)
        ccc_pkg::FACE_TOP:    res_c.ny = -ccc_pkg::ONE_Q14;
        ccc_pkg::FACE_BOTTOM: res_c.ny = ccc_pkg::ONE_Q14;
        ccc_pkg::FACE_LEFT:   res_c.nx = ccc_pkg::ONE_Q14;
        ccc_pkg::FACE_RIGHT:  res_c.nx = -ccc_pkg::ONE_Q14;
        default:              res_c.nx = '0;
      endcase
    end else if (mnz) begin
      res_c.nx = negn_x ? -qx : qx;
      res_c.ny = negn_y ? -qy : qy;
    end
    if (!dv_tag.t.hit) begin
      res_c = '0;
    end
  end

  // output register with one skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= dv_valid;
    end else if (dv_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        res_out <= res_skid;
      end
    end else if (!out_valid || out_ready) begin
      if (dv_valid) begin
        res_out <= res_c;
      end
    end else if (dv_valid) begin
      res_skid <= res_c;
    end
  end

  assign hit               = res_out.hit;
  assign normal_x          = res_out.nx;
  assign normal_y          = res_out.ny;
  assign contact_x         = res_out.cx;
  assign contact_y         = res_out.cy;
  assign separation        = res_out.sep;
  assign combined_friction = res_out.fric;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without output word");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled without output stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (normal_x == 16'sd0 && normal_y == 16'sd0 &&
      contact_x == 32'sd0 && contact_y == 32'sd0 && separation == 32'sd0 &&
      combined_friction == 17'd0))
    else $error("miss word carries non-zero fields");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (normal_x >= -16'sd16384 && normal_x <= 16'sd16384 &&
      normal_y >= -16'sd16384 && normal_y <= 16'sd16384))
    else $error("normal outside unit range");

endmodule
